>>> rtl/wlst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wlst_pkg
// Shared types, constants and helpers of the wide line strip tessellator.
// ----------------------------------------------------------------------------
package wlst_pkg;

  localparam int COORD_BITS = 32;
  localparam int CW = (COORD_BITS < 32) ? COORD_BITS : 32;

  localparam logic signed [33:0] SAT_HI = (34'sd1 <<< (CW - 1)) - 34'sd1;
  localparam logic signed [33:0] SAT_LO = -SAT_HI - 34'sd1;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_INDEX  = 1'b1;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [15:0]        line_width;
    logic [31:0]        point_color;
    logic               strip_start;
  } in_t;

  typedef struct packed {
    logic               item_kind;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic [31:0]        vertex_color;
    logic [31:0]        index_value;
    logic               degenerate;
    logic               last_of_item;
  } out_t;

  // one segment handed from the front to the back
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [31:0]        pc;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [31:0]        cc;
    logic [15:0]        pw;
    logic [32:0]        ax;
    logic [32:0]        ay;
    logic               dx_neg;
    logic               dx_zero;
    logic               dy_pos;
    logic               dy_zero;
    logic               degen;
    logic [31:0]        base;
  } job_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_NORM, BK_SQA, BK_SQB, BK_SQRT, BK_MULX, BK_MULY, BK_DIV,
    BK_SIGN, BK_EMIT
  } back_state_t;

  function automatic logic signed [31:0] sext_coord(input logic [31:0] v);
    logic signed [CW-1:0] t;
    t = v[CW-1:0];
    return 32'(t);
  endfunction

  function automatic logic signed [31:0] sat_coord(input logic signed [33:0] v);
    logic signed [33:0] r;
    if (v > SAT_HI) r = SAT_HI;
    else if (v < SAT_LO) r = SAT_LO;
    else r = v;
    return r[31:0];
  endfunction

  // triangle corners: 0 2 1, 1 2 3
  function automatic logic [1:0] corner(input logic [2:0] i);
    logic [1:0] c;
    unique case (i)
      3'd0: c = 2'd0;
      3'd1: c = 2'd2;
      3'd2: c = 2'd1;
      3'd3: c = 2'd1;
      3'd4: c = 2'd2;
      3'd5: c = 2'd3;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

>>> rtl/wlst_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wlst_front
// Takes points, keeps the previous point and the vertex counter, and pushes
// one segment job per point that closes a segment.
// ----------------------------------------------------------------------------
module wlst_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire wlst_pkg::in_t in_data,
  input  wire logic          cfg_we,
  input  wire logic [31:0]   cfg_data,
  input  wire logic          q_full,
  output logic               q_push,
  output wlst_pkg::job_t     q_job
);

  logic signed [31:0] prev_x, prev_y;
  logic [15:0]        prev_width;
  logic [31:0]        prev_color;
  logic               have_prev;
  logic [31:0]        vertex_counter;

  logic               take;
  logic signed [31:0] cx, cy;
  logic signed [32:0] dx, dy;

  assign in_stall = q_full;
  assign take = in_valid && !q_full;
  assign cx = wlst_pkg::sext_coord(in_data.point_x);
  assign cy = wlst_pkg::sext_coord(in_data.point_y);
  assign dx = 33'(cx) - 33'(prev_x);
  assign dy = 33'(cy) - 33'(prev_y);

  assign q_push = take && have_prev && !in_data.strip_start;

  always_comb begin
    q_job.px      = prev_x;
    q_job.py      = prev_y;
    q_job.pc      = prev_color;
    q_job.cx      = cx;
    q_job.cy      = cy;
    q_job.cc      = in_data.point_color;
    q_job.pw      = prev_width;
    q_job.ax      = dx[32] ? 33'(-dx) : 33'(dx);
    q_job.ay      = dy[32] ? 33'(-dy) : 33'(dy);
    q_job.dx_neg  = dx[32];
    q_job.dx_zero = (dx == 33'sd0);
    q_job.dy_pos  = !dy[32] && (dy != 33'sd0);
    q_job.dy_zero = (dy == 33'sd0);
    q_job.degen   = (dx == 33'sd0) && (dy == 33'sd0);
    q_job.base    = vertex_counter;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev      <= 1'b0;
      vertex_counter <= 32'd0;
      prev_x         <= '0;
      prev_y         <= '0;
      prev_width     <= '0;
      prev_color     <= '0;
    end else begin
      if (cfg_we) vertex_counter <= cfg_data;
      else if (q_push) vertex_counter <= vertex_counter + 32'd4;
      if (take) begin
        have_prev  <= 1'b1;
        prev_x     <= cx;
        prev_y     <= cy;
        prev_width <= in_data.line_width;
        prev_color <= in_data.point_color;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/wlst_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wlst_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module wlst_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire wlst_pkg::job_t push_job,
  output logic                full,
  output logic                q_valid,
  input  wire logic           pop,
  output wlst_pkg::job_t      pop_job
);

  wlst_pkg::job_t mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign pop_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/wlst_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wlst_back
// Segment sequencer: normalize, square, bit-serial square root, two
// bit-serial divides, then ten results through the output register.
// ----------------------------------------------------------------------------
module wlst_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  output logic                q_pop,
  input  wire wlst_pkg::job_t q_job,
  output logic                out_valid,
  input  wire logic           out_stall,
  output wlst_pkg::out_t      out_data
);

  localparam logic [32:0] NORM_HI = 33'd1 << 30;
  localparam logic [32:0] NORM_LO = 33'd1 << 29;

  wlst_pkg::back_state_t state, state_next;
  wlst_pkg::job_t        job;

  logic [32:0]        ax, ay, amax;
  logic [61:0]        sq;
  logic [61:0]        rt_v;
  logic [62:0]        rt_res, rt_bit, rt_try;
  logic [55:0]        wx, wy;
  logic [4:0]         cnt;
  logic signed [24:0] ox, oy;
  logic [3:0]         emit_idx;
  logic               load;
  logic [22:0]        half;
  logic [30:0]        len;
  wlst_pkg::out_t     rec;

  function automatic logic [55:0] div_step(input logic [55:0] w, input logic [30:0] d);
    logic [55:0] s;
    s = w << 1;
    if (s[55:24] >= {1'b0, d}) begin
      s[55:24] = s[55:24] - {1'b0, d};
      s[0] = 1'b1;
    end
    return s;
  endfunction

  assign amax   = (ax > ay) ? ax : ay;
  assign rt_try = rt_res + rt_bit;
  assign half   = {job.pw, 7'd0};
  assign len    = rt_res[30:0];
  assign load   = (state == wlst_pkg::BK_EMIT) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    unique case (state)
      wlst_pkg::BK_IDLE: if (q_valid) begin
        q_pop = 1'b1;
        state_next = q_job.degen ? wlst_pkg::BK_EMIT : wlst_pkg::BK_NORM;
      end
      wlst_pkg::BK_NORM: if (amax < NORM_HI && amax >= NORM_LO) state_next = wlst_pkg::BK_SQA;
      wlst_pkg::BK_SQA:  state_next = wlst_pkg::BK_SQB;
      wlst_pkg::BK_SQB:  state_next = wlst_pkg::BK_SQRT;
      wlst_pkg::BK_SQRT: if (cnt == 5'd31) state_next = wlst_pkg::BK_MULX;
      wlst_pkg::BK_MULX: state_next = wlst_pkg::BK_MULY;
      wlst_pkg::BK_MULY: state_next = wlst_pkg::BK_DIV;
      wlst_pkg::BK_DIV:  if (cnt == 5'd23) state_next = wlst_pkg::BK_SIGN;
      wlst_pkg::BK_SIGN: state_next = wlst_pkg::BK_EMIT;
      wlst_pkg::BK_EMIT: if (load && emit_idx == 4'd9) state_next = wlst_pkg::BK_IDLE;
      default:           state_next = wlst_pkg::BK_IDLE;
    endcase
  end

  // result record for the current emit slot
  always_comb begin
    rec = '0;
    rec.degenerate = job.degen;
    if (emit_idx < 4'd4) begin
      rec.item_kind = wlst_pkg::KIND_VERTEX;
      rec.vertex_color = emit_idx[1] ? job.cc : job.pc;
      rec.vertex_x = wlst_pkg::sat_coord(
        34'(emit_idx[1] ? job.cx : job.px) + (emit_idx[0] ? -34'(ox) : 34'(ox)));
      rec.vertex_y = wlst_pkg::sat_coord(
        34'(emit_idx[1] ? job.cy : job.py) + (emit_idx[0] ? -34'(oy) : 34'(oy)));
    end else begin
      rec.item_kind = wlst_pkg::KIND_INDEX;
      rec.index_value = job.base + 32'(wlst_pkg::corner(3'(emit_idx - 4'd4)));
      rec.last_of_item = (emit_idx == 4'd9);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= wlst_pkg::BK_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data <= rec;
    unique case (state)
      wlst_pkg::BK_IDLE: begin
        job      <= q_job;
        ax       <= q_job.ax;
        ay       <= q_job.ay;
        ox       <= '0;
        oy       <= '0;
        emit_idx <= 4'd0;
      end
      wlst_pkg::BK_NORM: begin
        if (amax >= NORM_HI) begin
          ax <= ax >> 1;
          ay <= ay >> 1;
        end else if (amax < NORM_LO) begin
          ax <= ax << 1;
          ay <= ay << 1;
        end
      end
      wlst_pkg::BK_SQA: sq <= 62'(ax[29:0] * ax[29:0]);
      wlst_pkg::BK_SQB: begin
        rt_v   <= sq + 62'(ay[29:0] * ay[29:0]);
        rt_res <= '0;
        rt_bit <= 63'd1 << 62;
        cnt    <= 5'd0;
      end
      wlst_pkg::BK_SQRT: begin
        if ({1'b0, rt_v} >= rt_try) begin
          rt_v   <= 62'({1'b0, rt_v} - rt_try);
          rt_res <= (rt_res >> 1) + rt_bit;
        end else begin
          rt_res <= rt_res >> 1;
        end
        rt_bit <= rt_bit >> 2;
        cnt    <= cnt + 5'd1;
      end
      wlst_pkg::BK_MULX: wx <= 56'(half * ay[29:0]) + 56'(len >> 1);
      wlst_pkg::BK_MULY: begin
        wy  <= 56'(half * ax[29:0]) + 56'(len >> 1);
        cnt <= 5'd0;
      end
      wlst_pkg::BK_DIV: begin
        wx  <= div_step(wx, len);
        wy  <= div_step(wy, len);
        cnt <= cnt + 5'd1;
      end
      wlst_pkg::BK_SIGN: begin
        // perpendicular is (-dy, dx)
        if (job.dy_zero) ox <= '0;
        else if (job.dy_pos) ox <= -25'(wx[23:0]);
        else ox <= 25'(wx[23:0]);
        if (job.dx_zero) oy <= '0;
        else if (job.dx_neg) oy <= -25'(wy[23:0]);
        else oy <= 25'(wy[23:0]);
      end
      wlst_pkg::BK_EMIT: if (load) emit_idx <= emit_idx + 4'd1;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/wide_line_strip_tessellator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wide_line_strip_tessellator_top
// Line strip points in, quad vertex and triangle index records out.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_data carries one point per transfer.
// A point that opens a strip (or the first after reset) is absorbed
// and produces nothing. Every other point closes a segment and yields
// ten records on out_valid/out_stall/out_data: four vertices, then six
// indices, the last flagged by last_of_item.
// The front takes a point per cycle while the two-entry job queue has room.
// The back sequencer runs each segment through n (0..29) normalize shifts,
// the 32-step square root and the 24-step divides; a zero-length segment
// skips them. Records leave one per cycle while out_stall is low.
// cfg_we/cfg_data load the vertex counter; write only while idle.
// Synchronous reset clears the previous point, the queue, the sequencer and
// the counter (to 0). A stalled receiver holds the output register and the
// sequencer; the queue and then in_stall back up in turn.
// ----------------------------------------------------------------------------
module wide_line_strip_tessellator_top (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire wlst_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output wlst_pkg::out_t      out_data,
  input  wire logic           cfg_we,
  input  wire logic [31:0]    cfg_data
);

  logic           q_full, q_push, q_valid, q_pop;
  wlst_pkg::job_t push_job, pop_job;

  wlst_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_data, .cfg_we, .cfg_data,
    .q_full, .q_push, .q_job(push_job)
  );

  wlst_queue u_queue (
    .clk, .rst, .push(q_push), .push_job, .full(q_full), .q_valid,
    .pop(q_pop), .pop_job
  );

  wlst_back u_back (
    .clk, .rst, .q_valid, .q_pop, .q_job(pop_job), .out_valid, .out_stall,
    .out_data
  );

endmodule
`default_nettype wire

>>> sim/wlst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlst_checker
// Watches the point and record channels of the tessellator, models each
// segment's quad and compares every record leaving the block in order.
// ----------------------------------------------------------------------------
module wlst_checker (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic           in_stall,
  input  wire wlst_pkg::in_t  in_data,
  input  wire logic           out_valid,
  input  wire logic           out_stall,
  input  wire wlst_pkg::out_t out_data,
  input  wire logic           cfg_we,
  input  wire logic [31:0]    cfg_data,
  output int                  fail_count,
  output int                  pending,
  output int                  records_seen,
  output int                  degen_seen
);

  wlst_pkg::out_t record_queue[$];

  logic signed [63:0] last_x, last_y;
  logic [15:0]        last_width;
  logic [31:0]        last_color;
  logic               have_last;
  logic [31:0]        vtx_count;

  assign pending = record_queue.size();

  task automatic report(input string what, input logic [127:0] got, input logic [127:0] want);
    $display("MISMATCH %s: got %h expected %h", what, got, want);
    fail_count++;
  endtask

  task automatic queue_rec(input wlst_pkg::out_t r);
    record_queue.insert(record_queue.size(), r);
  endtask

  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp(input logic signed [63:0] v);
    logic signed [63:0] hi, lo;
    hi = (64'sd1 <<< (wlst_pkg::CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi[31:0];
    if (v < lo) return lo[31:0];
    return v[31:0];
  endfunction

  function automatic wlst_pkg::out_t vertex_rec(input logic signed [63:0] x,
                                                input logic signed [63:0] y,
                                                input logic [31:0] c, input logic dg);
    wlst_pkg::out_t r;
    r = '0;
    r.item_kind = wlst_pkg::KIND_VERTEX;
    r.vertex_x = clamp(x);
    r.vertex_y = clamp(y);
    r.vertex_color = c;
    r.degenerate = dg;
    return r;
  endfunction

  task automatic tessellate_point(input wlst_pkg::in_t p);
    logic signed [63:0] cx, cy, dx, dy, ox, oy;
    logic [63:0] ax, ay, half, len, m, mx, my;
    logic dg;
    logic [1:0] corners [6];
    wlst_pkg::out_t r;
    corners = '{2'd0, 2'd2, 2'd1, 2'd1, 2'd2, 2'd3};
    cx = 64'(wlst_pkg::sext_coord(p.point_x));
    cy = 64'(wlst_pkg::sext_coord(p.point_y));
    if (p.strip_start || !have_last) begin
      last_x = cx; last_y = cy; last_width = p.line_width; last_color = p.point_color;
      have_last = 1'b1;
      return;
    end
    dx = cx - last_x;
    dy = cy - last_y;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    ox = 0; oy = 0; dg = 1'b0;
    if (ax == 0 && ay == 0) begin
      dg = 1'b1;
    end else begin
      half = 64'(last_width) * 128;
      // normalize so the larger magnitude sits in [2^29, 2^30)
      while ((ax > ay ? ax : ay) >= (64'd1 << 30)) begin ax = ax >> 1; ay = ay >> 1; end
      while ((ax > ay ? ax : ay) < (64'd1 << 29)) begin ax = ax << 1; ay = ay << 1; end
      len = root_floor(ax * ax + ay * ay);
      if (len == 0) len = 1;
      m = len / 2;
      mx = (half * ay + m) / len;
      my = (half * ax + m) / len;
      ox = dy > 0 ? -$signed(mx) : $signed(mx);
      oy = dx < 0 ? -$signed(my) : $signed(my);
      if (dy == 0) ox = 0;
      if (dx == 0) oy = 0;
    end
    queue_rec(vertex_rec(last_x + ox, last_y + oy, last_color, dg));
    queue_rec(vertex_rec(last_x - ox, last_y - oy, last_color, dg));
    queue_rec(vertex_rec(cx + ox, cy + oy, p.point_color, dg));
    queue_rec(vertex_rec(cx - ox, cy - oy, p.point_color, dg));
    for (int i = 0; i < 6; i++) begin
      r = '0;
      r.item_kind = wlst_pkg::KIND_INDEX;
      r.index_value = vtx_count + 32'(corners[i]);
      r.degenerate = dg;
      r.last_of_item = (i == 5);
      queue_rec(r);
    end
    vtx_count = vtx_count + 32'd4;
    if (dg) degen_seen++;
    last_x = cx; last_y = cy; last_width = p.line_width; last_color = p.point_color;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      record_queue.delete();
      have_last = 1'b0;
      last_x = 0; last_y = 0; last_width = 0; last_color = 0;
      vtx_count = 0;
      fail_count = 0;
      records_seen = 0;
      degen_seen = 0;
    end else begin
      if (cfg_we) vtx_count = cfg_data;
      if (in_valid && !in_stall) tessellate_point(in_data);
      if (out_valid && !out_stall) begin
        records_seen++;
        if (record_queue.size() == 0) begin
          report("unexpected record", 128'(out_data), 128'(0));
        end else begin
          wlst_pkg::out_t w;
          w = record_queue.pop_front();
          if (out_data.item_kind !== w.item_kind)
            report("item_kind", 128'(out_data.item_kind), 128'(w.item_kind));
          if (out_data.vertex_x !== w.vertex_x)
            report("vertex_x", 128'(out_data.vertex_x), 128'(w.vertex_x));
          if (out_data.vertex_y !== w.vertex_y)
            report("vertex_y", 128'(out_data.vertex_y), 128'(w.vertex_y));
          if (out_data.vertex_color !== w.vertex_color)
            report("vertex_color", 128'(out_data.vertex_color), 128'(w.vertex_color));
          if (out_data.index_value !== w.index_value)
            report("index_value", 128'(out_data.index_value), 128'(w.index_value));
          if (out_data.degenerate !== w.degenerate)
            report("degenerate", 128'(out_data.degenerate), 128'(w.degenerate));
          if (out_data.last_of_item !== w.last_of_item)
            report("last_of_item", 128'(out_data.last_of_item), 128'(w.last_of_item));
        end
      end
    end
  end

endmodule

>>> sim/wide_line_strip_tessellator_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wide_line_strip_tessellator_top_test
// Drives line strips through the tessellator with random idling on both
// channels and several vertex base settings; the checker scores the output.
// ----------------------------------------------------------------------------
module wide_line_strip_tessellator_top_test;

  localparam int WATCHDOG = 20000;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_stall;
  wlst_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  wlst_pkg::out_t out_data;
  logic           cfg_we = 1'b0;
  logic [31:0]    cfg_data = '0;

  int fail_count, pending, records_seen, degen_seen;
  int idle_pct = 20;
  int quiet_cycles = 0;
  int points_sent = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  wide_line_strip_tessellator_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  wlst_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending),
    .records_seen(records_seen), .degen_seen(degen_seen)
  );

  always @(posedge clk) begin
    if (!rst) out_stall <= ($urandom_range(99) < idle_pct);
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG);
      $display("Regression FAIL");
      $finish;
    end
  end

  // in_valid stays high after a transfer so points can follow back to back
  task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                            input logic [15:0] w, input logic [31:0] c, input logic s);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{point_x: x, point_y: y, line_width: w, point_color: c, strip_start: s};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    points_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_base(input logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord(input int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(2000)) - 1000) <<< 8;
      default: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
    endcase
  endfunction

  initial begin
    logic [31:0] x, y;
    int mode;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: first point without strip_start, extremes, zero length, axes
    send_point(32'h0001_0000, 32'h0002_0000, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    send_point(32'h0001_0000, 32'h0002_0000, 16'h0100, 32'h1122_3344, 1'b0);
    send_point(32'h0005_0000, 32'h0002_0000, 16'h0000, 32'h0000_0000, 1'b0);
    send_point(32'h0005_0000, 32'hFFF0_0000, 16'hFFFF, 32'hAABB_CCDD, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 32'h8000_0001, 1'b1);
    send_point(32'h8000_0000, 32'h8000_0000, 16'hFFFF, 32'h5555_AAAA, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 16'h8000, 32'hAAAA_5555, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h8000_0001, 16'h0001, 32'h0F0F_0F0F, 1'b0);
    send_point(32'h0000_0000, 32'h0000_0000, 16'h1234, 32'h0, 1'b1);
    drain();

    // counter wrap near the top of the range
    write_base(32'hFFFF_FFFE);
    send_point(32'h0, 32'h0, 16'h0200, 32'h1, 1'b1);
    send_point(32'h0003_0000, 32'h0004_0000, 16'h0200, 32'h2, 1'b0);
    send_point(32'hFFFD_0000, 32'h0004_0000, 16'h0200, 32'h3, 1'b0);
    send_point(32'hFFFD_0000, 32'h0004_0000, 16'h0200, 32'h4, 1'b0);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_base(32'd0);
        1: write_base(32'hFFFF_FFFF);
        2: write_base($urandom());
        default: write_base(32'h8000_0000);
      endcase
      idle_pct = (phase == 2) ? 0 : 20;
      for (int n = 0; n < 22; n++) begin
        mode = $urandom_range(2);
        x = rand_coord(mode);
        y = rand_coord(mode);
        if ($urandom_range(15) == 0) x = 32'h7FFF_FFFF;
        if ($urandom_range(15) == 0) y = 32'h8000_0000;
        // mostly strips of several points; a few repeats make zero segments
        if ($urandom_range(9) == 0) send_point(x, y, 16'($urandom()), $urandom(), 1'b0);
        send_point(x, y, 16'($urandom()), $urandom(), ($urandom_range(6) == 0));
        if (n == 11 && phase == 1) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
      end
      drain();
    end

    $display("Sent %0d points, checked %0d records, %0d zero-length segments.",
             points_sent, records_seen, degen_seen);
    $display("Vertex base covered zero, all ones, top bit, random and wrap.");
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

>>> wide_line_strip_tessellator_top.f
rtl/wlst_pkg.sv
rtl/wlst_front.sv
rtl/wlst_queue.sv
rtl/wlst_back.sv
rtl/wide_line_strip_tessellator_top.sv
sim/wlst_checker.sv
sim/wide_line_strip_tessellator_top_test.sv
